// File: design/homogeneous_4x4_point_transform_assert.svh
// Assertion macros shared by the checker of the point transform.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef HOMOGENEOUS_4X4_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_4X4_POINT_TRANSFORM_ASSERT_SVH

// Same-cycle implication.
`define H4PT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define H4PT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/h4pt_pkg.sv
// Shared types and constants of the homogeneous 4x4 point transform.
// No dependencies.
package h4pt_pkg;

  typedef enum logic {
    OP_MAP     = 1'b0,
    OP_PROJECT = 1'b1
  } op_t;

  localparam int PORT_W    = 32;
  localparam int REG_W     = 64;
  localparam int HALF_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int REG_SEL_W = 3;

  // Register indexes that reset to a nonzero value.
  localparam logic [REG_SEL_W-1:0] REG_ROW0_LOW  = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_ROW1_LOW  = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_ROW2_HIGH = 3'd5;
  localparam logic [REG_SEL_W-1:0] REG_ROW3_HIGH = 3'd7;

endpackage

// File: design/h4pt_div.sv
// Pipelined restoring divider: saturate(trunc(num * 2^F / den)).
// One quotient bit per stage; advances only while en is high. No package use.
module h4pt_div #(
  parameter int DW = 51,
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [CW-1:0] q,
  output logic                 sat
);

  localparam int XW = DW + CW + F;
  localparam logic [CW-1:0] MAX_Q = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MIN_Q = {1'b1, {(CW-1){1'b0}}};

  logic [DW-1:0] ua_r, ub_r;
  logic          nega_r;

  logic [XW-1:0] rem_r [CW+1];
  logic [DW-1:0] dv_r  [CW+1];
  logic [CW-1:0] qa_r  [CW+1];
  logic [CW:0]   neg_r;
  logic [CW:0]   ovf_r;

  logic signed [CW-1:0] q_r;
  logic                 sat_r;

  // Magnitudes and sign.
  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= num[DW-1] ? DW'(-num) : DW'(num);
      ub_r   <= den[DW-1] ? DW'(-den) : DW'(den);
      nega_r <= num[DW-1] ^ den[DW-1];
    end
  end

  // Scale the dividend and check for a quotient beyond CW bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= XW'(ua_r) << F;
      dv_r[0]  <= ub_r;
      qa_r[0]  <= '0;
      neg_r[0] <= nega_r;
      ovf_r[0] <= (XW'(ua_r) << F) >= (XW'(ub_r) << CW);
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_step
    logic [XW-1:0] cand;
    logic          ge;
    assign cand = XW'(dv_r[k]) << (CW - 1 - k);
    assign ge   = rem_r[k] >= cand;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? rem_r[k] - cand : rem_r[k];
        dv_r[k+1]  <= dv_r[k];
        qa_r[k+1]  <= {qa_r[k][CW-2:0], ge};
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // Apply sign and saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_r[CW]) begin
        sat_r <= 1'b1;
        q_r   <= neg_r[CW] ? MIN_Q : MAX_Q;
      end else if (neg_r[CW]) begin
        sat_r <= qa_r[CW] > MIN_Q;
        q_r   <= (qa_r[CW] > MIN_Q) ? MIN_Q : -qa_r[CW];
      end else begin
        sat_r <= qa_r[CW] > MAX_Q;
        q_r   <= (qa_r[CW] > MAX_Q) ? MAX_Q : qa_r[CW];
      end
    end
  end

  assign q   = q_r;
  assign sat = sat_r;

endmodule

// File: design/homogeneous_4x4_point_transform.sv
// Homogeneous 4x4 point transform, top level.
// Depends on h4pt_pkg and h4pt_div.
//
// Maps one point per clock through a row-vector 4x4 matrix held in eight
// 64-bit registers (two signed fixed-point coefficients each, identity after
// reset). Map mode returns [x y z 1]*M divided by w unless w is 0 or 1.0;
// project mode first solves z on the transformed plane, then divides x and y
// by w, and reports ok=0 when m22 is 0 or w is not positive. Coordinates
// saturate and clipped flags it. A new transaction is taken every cycle the
// output is not stalled. It holds two bit-per-stage divider sections: one
// solving z, then three in parallel dividing by w. A stalled output freezes
// the whole pipeline. Write configuration only while no transaction is in
// flight; cfg_ready is always high and writes to indexes 8 and up are
// dropped.
module homogeneous_4x4_point_transform
  import h4pt_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input point channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [PORT_W-1:0]    in_x,
  input  logic [PORT_W-1:0]    in_y,
  input  logic [PORT_W-1:0]    in_z,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PORT_W-1:0]    out_x,
  output logic [PORT_W-1:0]    out_y,
  output logic [PORT_W-1:0]    out_z,
  output logic                 out_ok,
  output logic                 out_clipped,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * CW;
  localparam int SW  = PW + 2;
  localparam int DA  = 2 * CW + 3 - F;
  localparam int DB  = (CW + 2 > F + 2) ? CW + 2 : F + 2;
  // width of a rounded dot product plus translation
  localparam int DW  = (DA > DB) ? DA : DB;
  localparam int DIV_LAT = CW + 3;

  localparam logic signed [DW-1:0] MAX_D = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_D = {{(DW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE_D = {{(DW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam logic [REG_W-1:0] ONE_LOW  = REG_W'(1) << F;
  localparam logic [REG_W-1:0] ONE_HIGH = ONE_LOW << HALF_W;

  // ---------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------
  logic [REG_W-1:0] coef_r [8];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        if (3'(i) == REG_ROW0_LOW || 3'(i) == REG_ROW2_HIGH) coef_r[3'(i)] <= ONE_LOW;
        else if (3'(i) == REG_ROW1_LOW || 3'(i) == REG_ROW3_HIGH) coef_r[3'(i)] <= ONE_HIGH;
        else coef_r[3'(i)] <= '0;
      end
    end else if (cfg_valid && cfg_ready && cfg_index[CFG_IDX_W-1:REG_SEL_W] == '0) begin
      coef_r[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Coefficient m(r,c): row r, column c; low CW bits of its half, signed.
  function automatic logic signed [CW-1:0] coef(input logic [1:0] r, input logic [1:0] c);
    logic [REG_W-1:0] sel;
    sel = coef_r[{r, c[1]}];
    return c[0] ? signed'(sel[HALF_W +: CW]) : signed'(sel[0 +: CW]);
  endfunction

  // Clamp a wide value to CW bits; returns {saturated, value}.
  function automatic logic [CW:0] clampc(input logic signed [DW-1:0] v);
    logic [CW:0] res;
    if (v > MAX_D)      res = {1'b1, MAX_C};
    else if (v < MIN_D) res = {1'b1, MIN_C};
    else                res = {1'b0, v[CW-1:0]};
    return res;
  endfunction

  // The whole pipeline advances unless a result is held at the output.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------------
  // Stage 0: capture the point
  // ---------------------------------------------------------------------
  logic                 v0_r;
  op_t                  op0_r;
  logic signed [CW-1:0] x0_r, y0_r, z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      op0_r <= op_t'(in_operation);
      x0_r  <= signed'(in_x[CW-1:0]);
      y0_r  <= signed'(in_y[CW-1:0]);
      z0_r  <= signed'(in_z[CW-1:0]);
    end
  end

  // ---------------------------------------------------------------------
  // Stages 1-2: plane depth numerator x*m02 + y*m12 + m32
  // ---------------------------------------------------------------------
  logic                 v1_r, v2_r;
  op_t                  op1_r, op2_r;
  logic signed [CW-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic signed [PW-1:0] pa1_r, pb1_r;
  logic signed [SW-1:0] zsum;
  logic signed [SW-1:0] zsh;
  logic signed [DW-1:0] zn_nxt, zn2_r;

  assign zsum   = SW'(pa1_r) + SW'(pb1_r);
  assign zsh    = zsum >>> F;
  assign zn_nxt = DW'(zsh) + DW'(coef(2'd3, 2'd2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= op0_r;
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      z1_r  <= z0_r;
      pa1_r <= PW'(x0_r) * PW'(coef(2'd0, 2'd2));
      pb1_r <= PW'(y0_r) * PW'(coef(2'd1, 2'd2));
      op2_r <= op1_r;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
      zn2_r <= zn_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Depth divider and its side line
  // ---------------------------------------------------------------------
  typedef struct packed {
    op_t                  op;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } sba_t;

  sba_t                 sba_r [DIV_LAT];
  logic [DIV_LAT-1:0]   sva_r;
  logic signed [CW-1:0] zq;
  logic                 zq_sat;

  h4pt_div #(.DW(DW), .CW(CW), .F(F)) u_div_z (
    .clk (clk),
    .en  (adv),
    .num (zn2_r),
    .den (DW'(coef(2'd2, 2'd2))),
    .q   (zq),
    .sat (zq_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) sva_r <= '0;
    else if (adv) sva_r <= {sva_r[DIV_LAT-2:0], v2_r};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sba_r[0] <= '{op: op2_r, x: x2_r, y: y2_r, z: z2_r};
      for (int i = 1; i < DIV_LAT; i++) sba_r[i] <= sba_r[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: pick the depth (negated solved depth in project mode)
  // ---------------------------------------------------------------------
  logic                 v3_r;
  op_t                  op3_r;
  logic signed [CW-1:0] x3_r, y3_r, z3_r;
  logic                 zs3_r;
  logic                 proj_a;

  assign proj_a = sba_r[DIV_LAT-1].op == OP_PROJECT;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= sva_r[DIV_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      op3_r <= sba_r[DIV_LAT-1].op;
      x3_r  <= sba_r[DIV_LAT-1].x;
      y3_r  <= sba_r[DIV_LAT-1].y;
      if (proj_a) z3_r <= (zq == MIN_C) ? MAX_C : -zq;
      else        z3_r <= sba_r[DIV_LAT-1].z;
      zs3_r <= proj_a && (zq_sat || zq == MIN_C);
    end
  end

  // ---------------------------------------------------------------------
  // Stages 4-5: twelve products, then four rounded dot products
  // ---------------------------------------------------------------------
  logic                 v4_r, v5_r;
  op_t                  op4_r, op5_r;
  logic                 zs4_r, zs5_r;
  logic signed [PW-1:0] p4_r [4][3];
  logic signed [DW-1:0] r5_nxt [4];
  logic signed [DW-1:0] r5_r [4];

  always_comb begin
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] sh;
    for (int c = 0; c < 4; c++) begin
      s  = SW'(p4_r[c][0]) + SW'(p4_r[c][1]) + SW'(p4_r[c][2]);
      sh = s >>> F;
      r5_nxt[c] = DW'(sh) + DW'(coef(2'd3, 2'(c)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      op4_r <= op3_r;
      zs4_r <= zs3_r;
      for (int c = 0; c < 4; c++) begin
        p4_r[c][0] <= PW'(x3_r) * PW'(coef(2'd0, 2'(c)));
        p4_r[c][1] <= PW'(y3_r) * PW'(coef(2'd1, 2'(c)));
        p4_r[c][2] <= PW'(z3_r) * PW'(coef(2'd2, 2'(c)));
      end
      op5_r <= op4_r;
      zs5_r <= zs4_r;
      for (int c = 0; c < 4; c++) r5_r[c] <= r5_nxt[c];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: decide divide / bypass / refuse, clamp the bypass values
  // ---------------------------------------------------------------------
  typedef struct packed {
    op_t                  op;
    logic                 zs;
    logic                 dv;
    logic                 rf;
    logic [CW:0]          cx;
    logic [CW:0]          cy;
    logic [CW:0]          cz;
  } sbb_t;

  logic                 v6_r;
  sbb_t                 sb6_r;
  logic signed [DW-1:0] r6_r [4];
  logic                 m22_zero;
  logic                 w_nonpos;

  assign m22_zero = coef(2'd2, 2'd2) == '0;
  assign w_nonpos = r5_r[3][DW-1] || r5_r[3] == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) r6_r[c] <= r5_r[c];
      sb6_r.op <= op5_r;
      sb6_r.zs <= zs5_r;
      sb6_r.dv <= r5_r[3] != '0 && r5_r[3] != ONE_D;
      sb6_r.rf <= op5_r == OP_PROJECT && (m22_zero || w_nonpos);
      sb6_r.cx <= clampc(r5_r[0]);
      sb6_r.cy <= clampc(r5_r[1]);
      sb6_r.cz <= clampc(r5_r[2]);
    end
  end

  // ---------------------------------------------------------------------
  // Perspective dividers and their side line
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] qx, qy, qz;
  logic                 sx, sy, sz;
  sbb_t                 sbb_r [DIV_LAT];
  logic [DIV_LAT-1:0]   svb_r;

  h4pt_div #(.DW(DW), .CW(CW), .F(F)) u_div_x (
    .clk (clk), .en (adv), .num (r6_r[0]), .den (r6_r[3]), .q (qx), .sat (sx)
  );
  h4pt_div #(.DW(DW), .CW(CW), .F(F)) u_div_y (
    .clk (clk), .en (adv), .num (r6_r[1]), .den (r6_r[3]), .q (qy), .sat (sy)
  );
  h4pt_div #(.DW(DW), .CW(CW), .F(F)) u_div_zz (
    .clk (clk), .en (adv), .num (r6_r[2]), .den (r6_r[3]), .q (qz), .sat (sz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) svb_r <= '0;
    else if (adv) svb_r <= {svb_r[DIV_LAT-2:0], v6_r};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sbb_r[0] <= sb6_r;
      for (int i = 1; i < DIV_LAT; i++) sbb_r[i] <= sbb_r[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: output register
  // ---------------------------------------------------------------------
  sbb_t                 sbo;
  logic                 proj_b;
  logic                 out_valid_r, ok_r, clip_r;
  logic signed [CW-1:0] ox_r, oy_r, oz_r;

  assign sbo    = sbb_r[DIV_LAT-1];
  assign proj_b = sbo.op == OP_PROJECT;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= svb_r[DIV_LAT-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sbo.rf) begin
        // refused projection: zero coordinates, no clip
        ok_r   <= 1'b0;
        ox_r   <= '0;
        oy_r   <= '0;
        oz_r   <= '0;
        clip_r <= 1'b0;
      end else if (sbo.dv) begin
        ok_r   <= 1'b1;
        ox_r   <= qx;
        oy_r   <= qy;
        oz_r   <= proj_b ? '0 : qz;
        clip_r <= sbo.zs || sx || sy || (!proj_b && sz);
      end else begin
        ok_r   <= 1'b1;
        ox_r   <= sbo.cx[CW-1:0];
        oy_r   <= sbo.cy[CW-1:0];
        oz_r   <= proj_b ? '0 : sbo.cz[CW-1:0];
        clip_r <= sbo.zs || sbo.cx[CW] || sbo.cy[CW] || (!proj_b && sbo.cz[CW]);
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x       = PORT_W'(ox_r);
  assign out_y       = PORT_W'(oy_r);
  assign out_z       = PORT_W'(oz_r);
  assign out_ok      = ok_r;
  assign out_clipped = clip_r;

endmodule

// File: design/h4pt_chk.sv
// Port-level checker for the point transform, bound to the top level.
// Depends on h4pt_pkg and the assertion macro header.
`include "homogeneous_4x4_point_transform_assert.svh"

module h4pt_chk
  import h4pt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PORT_W-1:0] out_x,
  input logic [PORT_W-1:0] out_y,
  input logic [PORT_W-1:0] out_z,
  input logic              out_ok,
  input logic              out_clipped
);

  // A refused projection carries zero coordinates and no clip.
  `H4PT_ASSERT_NOW(a_refused_zero, out_valid && !out_ok, out_x == 0 && out_y == 0 && out_z == 0 && !out_clipped, "refused result not cleared")

  // Input backpressure only comes from a held result.
  `H4PT_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

  // A held result stays valid and keeps out_x, out_ok and out_clipped.
  `H4PT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_ok) && $stable(out_clipped), "held result changed")

endmodule

bind homogeneous_4x4_point_transform h4pt_chk u_h4pt_chk (.*);
